[sv/additive_lagged_fibonacci_prng_unit_macros.svh]
// ----------------------------------------------------------------------------
// additive lagged-fibonacci prng unit assertion macros
// shared concurrent assertion forms for the prng unit and its parts
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_LAGGED_FIBONACCI_PRNG_UNIT_MACROS_SVH
`define ADDITIVE_LAGGED_FIBONACCI_PRNG_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ALFP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alfp same-cycle property violated");

// consequent must hold in the cycle after the antecedent
`define ALFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alfp next-cycle property violated");

`endif

[sv/alfp_pkg.sv]
// ----------------------------------------------------------------------------
// alfp_pkg
// shared constants, state codes and control structs of the prng unit
// ----------------------------------------------------------------------------
package alfp_pkg;

  localparam int FIELD_W   = 32;
  localparam int LAG_LONG  = 55;
  localparam int LAG_SHORT = 24;
  localparam int LCG_MUL   = 3;
  localparam int LCG_ADD   = 257;
  localparam int LCG_W     = FIELD_W + 2;

  typedef enum logic [4:0] {
    ST_FILL = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } alfp_state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/alfp_req_if.sv]
// ----------------------------------------------------------------------------
// alfp_req_if
// draw request channel: range bounds and threshold
// ----------------------------------------------------------------------------
interface alfp_req_if;

  logic                                valid;
  logic                                ready;
  logic signed [alfp_pkg::FIELD_W-1:0] range_min;
  logic signed [alfp_pkg::FIELD_W-1:0] range_max;
  logic        [alfp_pkg::FIELD_W-1:0] threshold;

  modport source (
    output valid, range_min, range_max, threshold,
    input  ready
  );

  modport sink (
    input  valid, range_min, range_max, threshold,
    output ready
  );

endinterface

[sv/alfp_rsp_if.sv]
// ----------------------------------------------------------------------------
// alfp_rsp_if
// draw result channel: raw value, ranged value and flags
// ----------------------------------------------------------------------------
interface alfp_rsp_if;

  logic                                valid;
  logic                                ready;
  logic        [alfp_pkg::FIELD_W-1:0] raw_value;
  logic signed [alfp_pkg::FIELD_W-1:0] ranged_value;
  logic                                below_threshold;
  logic                                span_zero;

  modport source (
    output valid, raw_value, ranged_value, below_threshold, span_zero,
    input  ready
  );

  modport sink (
    input  valid, raw_value, ranged_value, below_threshold, span_zero,
    output ready
  );

endinterface

[sv/alfp_mod_unit.sv]
// ----------------------------------------------------------------------------
// alfp_mod_unit
// serial restoring remainder unit, one dividend bit shifted in per cycle
// ----------------------------------------------------------------------------
`include "additive_lagged_fibonacci_prng_unit_macros.svh"

module alfp_mod_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  alfp_pkg::div_ctrl_t           ctrl,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [alfp_pkg::FIELD_W-1:0]  divisor,
  output alfp_pkg::div_stat_t           stat,
  output logic [alfp_pkg::FIELD_W-1:0]  remainder
);

  localparam int FW    = alfp_pkg::FIELD_W;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [FW-1:0]         rem_r;
  logic [FW-1:0]         rem_nxt;
  logic [FW-1:0]         dsr_r;
  logic [VALUE_BITS-1:0] dvd_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [FW:0]           trial;
  logic [FW:0]           diff;

  always_comb begin
    trial = {rem_r, dvd_r[VALUE_BITS-1]};
    diff  = trial - {1'b0, dsr_r};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = diff[FW-1:0];
    end else begin
      rem_nxt = trial[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VALUE_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[VALUE_BITS-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

  // remainder below the divisor once finished
  `ALFP_ASSERT_SAME(a_rem_bound, clk, rst_n, done_r && (dsr_r != '0), rem_r < dsr_r)
  // a start always leads into the busy phase
  `ALFP_ASSERT_NEXT(a_start_busy, clk, rst_n, ctrl.start, busy_r)
  // done is a single-cycle pulse
  `ALFP_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r)

endmodule

[sv/additive_lagged_fibonacci_prng_unit.sv]
// ----------------------------------------------------------------------------
// additive_lagged_fibonacci_prng_unit
// additive lagged-fibonacci generator (lags 55 and 24) with ranged and
// threshold outputs.
//
// Each draw transaction sums two table entries into a new raw value, stores
// it back, and reduces it modulo (range_max - range_min) in a serial
// remainder unit that takes one quotient bit per cycle. A draw passes
// through the SUM, DIV and DONE states from acceptance until its result
// sits in the output register. A new transaction is accepted once the
// previous result has moved into the output register, even while that
// result still waits to be taken. After reset and after every seed write
// the table is refilled from the seed, one entry a cycle, and no
// transaction is accepted until the last entry is written.
// ----------------------------------------------------------------------------
`include "additive_lagged_fibonacci_prng_unit_macros.svh"

module additive_lagged_fibonacci_prng_unit #(
  parameter int STATE_WORDS = 57,
  parameter int VALUE_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [alfp_pkg::FIELD_W-1:0] cfg_wdata,
  alfp_req_if.sink                     in_req,
  alfp_rsp_if.source                   out_rsp
);

  localparam int FW    = alfp_pkg::FIELD_W;
  localparam int IDX_W = $clog2(STATE_WORDS);
  localparam logic [IDX_W:0]   DEPTH      = (IDX_W + 1)'(STATE_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] R1_INIT    = '0;
  localparam logic [IDX_W-1:0] R2_INIT    =
    IDX_W'(alfp_pkg::LAG_LONG - alfp_pkg::LAG_SHORT);
  localparam logic [IDX_W-1:0] W_INIT     = IDX_W'(alfp_pkg::LAG_LONG);

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] inc;
    inc = {1'b0, idx} + 1'b1;
    if (inc >= DEPTH) begin
      inc = inc - DEPTH;
    end
    return inc[IDX_W-1:0];
  endfunction

  function automatic logic [VALUE_BITS-1:0] lcg(input logic [VALUE_BITS-1:0] prev);
    logic [alfp_pkg::LCG_W-1:0] wide;
    wide = alfp_pkg::LCG_W'(prev) * alfp_pkg::LCG_W'(alfp_pkg::LCG_MUL)
         + alfp_pkg::LCG_W'(alfp_pkg::LCG_ADD);
    return wide[VALUE_BITS-1:0];
  endfunction

  alfp_pkg::alfp_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] lag_mem [STATE_WORDS];
  logic [VALUE_BITS-1:0] a_q;
  logic [VALUE_BITS-1:0] b_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic                  rd_en;

  logic [IDX_W-1:0]      fill_idx_r;
  logic [VALUE_BITS-1:0] fill_val_r;
  logic [IDX_W-1:0]      r1_idx_r;
  logic [IDX_W-1:0]      r2_idx_r;
  logic [IDX_W-1:0]      w_idx_r;

  logic [FW-1:0]         rmin_r;
  logic [FW-1:0]         thr_r;
  logic [FW-1:0]         span_r;
  logic                  zero_r;
  logic [VALUE_BITS-1:0] raw_r;
  logic                  below_r;

  logic [VALUE_BITS:0]   sum_w;
  logic [VALUE_BITS-1:0] raw;
  logic                  accept;
  logic                  out_free;

  logic                  out_valid_r;
  logic [FW-1:0]         out_raw_r;
  logic [FW-1:0]         out_ranged_r;
  logic                  out_below_r;
  logic                  out_zero_r;

  alfp_pkg::div_ctrl_t   div_ctrl;
  alfp_pkg::div_stat_t   div_stat;
  logic [FW-1:0]         div_rem;

  assign sum_w    = {1'b0, a_q} + {1'b0, b_q};
  assign raw      = sum_w[VALUE_BITS-1:0];
  assign in_req.ready = (state_r == alfp_pkg::ST_IDLE) && !cfg_we;
  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;
  assign rd_en    = accept;
  assign div_ctrl.start = (state_r == alfp_pkg::ST_SUM);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = w_idx_r;
    mem_wdata = raw;
    unique case (state_r)
      alfp_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_idx_r;
        mem_wdata = fill_val_r;
      end
      alfp_pkg::ST_SUM: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alfp_pkg::ST_FILL: begin
        if (fill_idx_r == LAST_IDX) state_nxt = alfp_pkg::ST_IDLE;
      end
      alfp_pkg::ST_IDLE: begin
        if (accept) state_nxt = alfp_pkg::ST_SUM;
      end
      alfp_pkg::ST_SUM: begin
        state_nxt = alfp_pkg::ST_DIV;
      end
      alfp_pkg::ST_DIV: begin
        if (div_stat.done) state_nxt = alfp_pkg::ST_DONE;
      end
      alfp_pkg::ST_DONE: begin
        if (out_free) state_nxt = alfp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = alfp_pkg::ST_FILL;
      end
    endcase
    if (cfg_we) state_nxt = alfp_pkg::ST_FILL;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alfp_pkg::ST_FILL;
      fill_idx_r  <= '0;
      fill_val_r  <= VALUE_BITS'(1);
      r1_idx_r    <= R1_INIT;
      r2_idx_r    <= R2_INIT;
      w_idx_r     <= W_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        fill_idx_r <= '0;
        fill_val_r <= cfg_wdata[VALUE_BITS-1:0];
      end else if (state_r == alfp_pkg::ST_FILL) begin
        fill_idx_r <= fill_idx_r + 1'b1;
        fill_val_r <= lcg(fill_val_r);
        if (fill_idx_r == LAST_IDX) begin
          r1_idx_r <= R1_INIT;
          r2_idx_r <= R2_INIT;
          w_idx_r  <= W_INIT;
        end
      end else if (accept) begin
        r1_idx_r <= advance(r1_idx_r);
        r2_idx_r <= advance(r2_idx_r);
        w_idx_r  <= advance(w_idx_r);
      end
      if ((state_r == alfp_pkg::ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // lag table
  always_ff @(posedge clk) begin
    if (mem_we) lag_mem[mem_waddr] <= mem_wdata;
    if (rd_en) begin
      a_q <= lag_mem[r1_idx_r];
      b_q <= lag_mem[r2_idx_r];
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rmin_r <= in_req.range_min;
      thr_r  <= in_req.threshold;
      span_r <= in_req.range_max - in_req.range_min;
      zero_r <= (in_req.range_max == in_req.range_min);
    end
    if (state_r == alfp_pkg::ST_SUM) begin
      raw_r   <= raw;
      below_r <= (FW'(raw) <= thr_r);
    end
    if ((state_r == alfp_pkg::ST_DONE) && out_free) begin
      out_raw_r    <= FW'(raw_r);
      out_ranged_r <= zero_r ? rmin_r : (rmin_r + div_rem);
      out_below_r  <= below_r;
      out_zero_r   <= zero_r;
    end
  end

  alfp_mod_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .dividend  (raw),
    .divisor   (span_r),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.raw_value       = out_raw_r;
  assign out_rsp.ranged_value    = out_ranged_r;
  assign out_rsp.below_threshold = out_below_r;
  assign out_rsp.span_zero       = out_zero_r;

  // an accepted transaction goes straight to the table update
  `ALFP_ASSERT_NEXT(a_accept_sum, clk, rst_n, accept, state_r == alfp_pkg::ST_SUM)
  // the store address is inside the table
  `ALFP_ASSERT_SAME(a_store_idx, clk, rst_n, state_r == alfp_pkg::ST_SUM, w_idx_r < DEPTH)
  // the remainder unit is running while waiting for it
  `ALFP_ASSERT_SAME(a_div_run, clk, rst_n, state_r == alfp_pkg::ST_DIV,
    div_stat.busy || div_stat.done)

endmodule

[tb/alfp_draw_checker.sv]
// ----------------------------------------------------------------------------
// alfp_draw_checker
// Watches the draw request and result channels of the prng unit. It keeps
// its own copy of the lag table, indices and seed, works out the expected
// result of each accepted request and compares every accepted result field
// by field, oldest expectation first.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module alfp_draw_checker #(
  parameter int STATE_WORDS = 57,
  parameter int VALUE_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [alfp_pkg::FIELD_W-1:0] cfg_wdata,
  alfp_req_if                          req,
  alfp_rsp_if                          rsp,
  output int                           fail_count,
  output int                           pending_count,
  output int                           draws_checked
);

  localparam int FW = alfp_pkg::FIELD_W;

  typedef struct packed {
    logic [FW-1:0] raw_value;
    logic [FW-1:0] ranged_value;
    logic          below_threshold;
    logic          span_zero;
  } draw_result_t;

  localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;

  logic [FW-1:0]      lag_table [STATE_WORDS];
  int                 first_idx;
  int                 second_idx;
  int                 write_idx;
  draw_result_t       expected_draws [$];
  draw_result_t       want;
  int                 mismatches = 0;
  int                 checked    = 0;

  assign fail_count    = mismatches;
  assign draws_checked = checked;

  function automatic void reseed_table(input logic [FW-1:0] seed);
    logic [63:0] next_word;
    lag_table[0] = seed & VALUE_MASK[FW-1:0];
    for (int i = 1; i < STATE_WORDS; i++) begin
      next_word    = 64'(alfp_pkg::LCG_MUL) * 64'(lag_table[i-1])
                   + 64'(alfp_pkg::LCG_ADD);
      lag_table[i] = next_word[FW-1:0] & VALUE_MASK[FW-1:0];
    end
    first_idx  = 0;
    second_idx = alfp_pkg::LAG_LONG - alfp_pkg::LAG_SHORT;
    write_idx  = alfp_pkg::LAG_LONG;
  endfunction

  function automatic draw_result_t next_draw(input logic [FW-1:0] lo,
                                             input logic [FW-1:0] hi,
                                             input logic [FW-1:0] thr);
    logic [FW-1:0] raw;
    logic [FW-1:0] span;
    draw_result_t  r;
    raw        = (lag_table[first_idx] + lag_table[second_idx]) & VALUE_MASK[FW-1:0];
    first_idx  = (first_idx + 1) % STATE_WORDS;
    second_idx = (second_idx + 1) % STATE_WORDS;
    write_idx  = (write_idx + 1) % STATE_WORDS;
    lag_table[write_idx] = raw;
    span              = hi - lo;
    r.raw_value       = raw;
    r.span_zero       = (span == '0);
    r.ranged_value    = (span == '0) ? lo : lo + (raw % span);
    r.below_threshold = (raw <= thr);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [FW-1:0] got,
                                 input logic [FW-1:0] exp_word);
    mismatches++;
    $display("mismatch at %0t: %s got %08h exp %08h (transaction %0d)",
             $time, what, got, exp_word, checked);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reseed_table(32'd1);
      expected_draws.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_draws.size() == 0) begin
          report_mismatch("result with no draw pending", rsp.raw_value, '0);
        end else begin
          want = expected_draws.pop_front();
          if (rsp.raw_value !== want.raw_value)
            report_mismatch("raw_value", rsp.raw_value, want.raw_value);
          if (rsp.ranged_value !== want.ranged_value)
            report_mismatch("ranged_value", rsp.ranged_value, want.ranged_value);
          if (rsp.below_threshold !== want.below_threshold)
            report_mismatch("below_threshold", 32'(rsp.below_threshold),
                            32'(want.below_threshold));
          if (rsp.span_zero !== want.span_zero)
            report_mismatch("span_zero", 32'(rsp.span_zero), 32'(want.span_zero));
          checked++;
        end
      end
      if (cfg_we) begin
        reseed_table(cfg_wdata);
      end
      if (req.valid && req.ready) begin
        expected_draws.push_back(next_draw(req.range_min, req.range_max, req.threshold));
      end
    end
    pending_count <= expected_draws.size();
  end

endmodule

[tb/additive_lagged_fibonacci_prng_unit_tb.sv]
// ----------------------------------------------------------------------------
// additive_lagged_fibonacci_prng_unit_tb
// Drives draw requests into the prng unit under several seeds: a directed
// set of range and threshold corner cases, then random requests with random
// idling on both channels, a long result back-pressure stretch and drains
// between seed writes. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module additive_lagged_fibonacci_prng_unit_tb;

  localparam int FW          = alfp_pkg::FIELD_W;
  localparam int STATE_WORDS = 57;
  localparam int VALUE_BITS  = 32;
  localparam int DRAW_CYCLES = VALUE_BITS + 3;
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 4000;

  localparam logic [FW-1:0] BOUNDARY [6] = '{
    32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff,
    32'h8000_0000, 32'h8000_0001, 32'hffff_ffff
  };

  logic          clk = 1'b0;
  logic          rst_n;
  logic          cfg_we;
  logic [FW-1:0] cfg_wdata;

  int fail_count;
  int pending_count;
  int draws_checked;
  int items_sent    = 0;
  int seeds_written = 0;
  int idle_cycles   = 0;
  int hold_request  = 0;
  bit no_idling     = 1'b0;

  alfp_req_if in_req ();
  alfp_rsp_if out_rsp ();

  additive_lagged_fibonacci_prng_unit #(
    .STATE_WORDS (STATE_WORDS),
    .VALUE_BITS  (VALUE_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_rsp   (out_rsp)
  );

  alfp_draw_checker #(
    .STATE_WORDS (STATE_WORDS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req           (in_req),
    .rsp           (out_rsp),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .draws_checked (draws_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no transaction on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d draws pending", idle_cycles, pending_count);
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin : receiver
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
        out_rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!no_idling && $urandom_range(0, 2) == 0) begin
        out_rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic draw(input logic [FW-1:0] lo, input logic [FW-1:0] hi,
                      input logic [FW-1:0] thr);
    if (!no_idling && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.range_min <= lo;
    in_req.range_max <= hi;
    in_req.threshold <= thr;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || !in_req.ready) @(posedge clk);
  endtask

  task automatic write_seed(input logic [FW-1:0] seed);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seeds_written++;
  endtask

  task automatic random_run(input int count);
    logic [FW-1:0] lo;
    logic [FW-1:0] hi;
    logic [FW-1:0] thr;
    for (int k = 0; k < count; k++) begin
      lo = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2: hi = $urandom;
        3, 4:    hi = lo + $urandom_range(1, 16);
        5:       hi = lo;
        6:       hi = lo + (32'd1 << $urandom_range(0, 31));
        7: begin
          lo = BOUNDARY[$urandom_range(0, 5)];
          hi = BOUNDARY[$urandom_range(0, 5)];
        end
        8:       hi = lo - $urandom_range(1, 100000);
        default: hi = lo + $urandom_range(1, 100000);
      endcase
      case ($urandom_range(0, 7))
        0:       thr = '0;
        1:       thr = '1;
        2, 3:    thr = $urandom >> $urandom_range(0, 31);
        default: thr = $urandom;
      endcase
      draw(lo, hi, thr);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_req.valid     = 1'b0;
    in_req.range_min = '0;
    in_req.range_max = '0;
    in_req.threshold = '0;
    out_rsp.ready    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // corner cases under the reset seed
    draw(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    draw(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    draw(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    draw(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    draw(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    draw(32'h0000_0000, 32'h0000_0001, 32'h0000_0001);
    draw(32'hffff_ffff, 32'h0000_0000, 32'hffff_fffe);
    draw(32'h0000_0001, 32'h0000_0000, 32'h1234_5678);
    draw(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000);
    draw(32'h8000_0000, 32'h0000_0000, $urandom);
    draw(32'h0000_0000, 32'h8000_0000, $urandom);
    draw(32'hffff_0000, 32'h0001_0000, $urandom);
    draw(-32'sd100, 32'sd100, $urandom);
    draw(32'sd100, -32'sd100, $urandom);
    draw(32'h0000_0000, 32'h0000_0007, $urandom);
    draw(32'h4000_0000, 32'hc000_0000, 32'h0000_ffff);
    draw(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    draw(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    draw($urandom, $urandom, $urandom);
    draw($urandom, $urandom, $urandom);

    write_seed(32'h0000_0000);
    random_run(290);

    write_seed(32'hffff_ffff);
    random_run(120);
    hold_request = LONG_HOLD;
    random_run(170);

    write_seed($urandom);
    random_run(200);
    drain();
    random_run(200);

    write_seed(32'h0000_0001);
    random_run(220);
    no_idling = 1'b1;
    random_run(200);

    drain();
    repeat (2 * DRAW_CYCLES) @(posedge clk);

    $display("%0d draws offered, %0d results checked over %0d seed writes",
             items_sent, draws_checked, seeds_written);
    $display("mismatches: %0d, draws still pending: %0d", fail_count, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[additive_lagged_fibonacci_prng_unit.f]
+incdir+sv
sv/alfp_pkg.sv
sv/alfp_req_if.sv
sv/alfp_rsp_if.sv
sv/alfp_mod_unit.sv
sv/additive_lagged_fibonacci_prng_unit.sv
tb/alfp_draw_checker.sv
tb/additive_lagged_fibonacci_prng_unit_tb.sv
